/* src/ldif_pkg.sv */
// Package for the local deviation image filter: item structs, register
// codes, back-end state codes and default sizes. No dependencies.
package ldif_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_GAP    = 7;

  // Register reset values
  localparam logic [2:0]  RST_GAP    = 3'd1;
  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [10:0] RST_HEIGHT = 11'd480;

  // Arithmetic constants: 255^2 scale and the 0..100 full scale
  localparam int SCALE_FACTOR = 65025;
  localparam int FULL_SCALE   = 100;
  localparam logic [7:0] OUT_TOP = 8'd255;

  // Queue depths (powers of two)
  localparam int JQ_DEPTH  = 2;
  localparam int RES_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LEFT_GAP  = 3'd0,
    CFG_RIGHT_GAP = 3'd1,
    CFG_UPPER_GAP = 3'd2,
    CFG_LOWER_GAP = 3'd3,
    CFG_WIDTH     = 3'd4,
    CFG_HEIGHT    = 3'd5
  } cfg_idx_t;

  // Input item
  typedef struct packed {
    logic       mode;
    logic [7:0] pixel;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] deviation;
    logic       frame_last;
  } out_item_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    B_IDLE,
    B_WALK,
    B_DRAIN,
    B_MUL,
    B_SUB,
    B_SCALE,
    B_ROOT,
    B_SAT,
    B_DIV,
    B_PUSH
  } back_state_t;

endpackage

/* src/ldif_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ldif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/ldif_front.sv */
// Front end: configuration registers, raster positions, line-store writes
// and window jobs for the back end. Depends on ldif_pkg.
module ldif_front #(
  parameter int MAX_WIDTH  = ldif_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ldif_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_GAP    = ldif_pkg::DEF_MAX_GAP,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int SB  = $clog2(2 * MAX_GAP + 2),
  localparam int NWB = $clog2(2 * MAX_GAP + 2)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               accept,
  input  ldif_pkg::in_item_t item,
  output logic               ram_we,
  output logic [SB+CW-1:0]   ram_waddr,
  output logic [7:0]         ram_wdata,
  output logic               job_push,
  output logic [CW-1:0]      job_x0,
  output logic [CW-1:0]      job_x1,
  output logic [SB-1:0]      job_slot,
  output logic [NWB-1:0]     job_cols,
  output logic [NWB-1:0]     job_rows,
  output logic               job_last,
  output logic               in_complete
);

  localparam int STORE_ROWS = 2 * MAX_GAP + 2;
  localparam int GB = $clog2(MAX_GAP + 1);

  // Configuration registers
  logic [2:0]  left_gap, right_gap, upper_gap, lower_gap;
  logic [10:0] img_w, img_h;
  logic        cfg_hit;

  // Raster positions
  logic [CW-1:0] in_col, in_col_next, out_col, out_col_next;
  logic [RW-1:0] in_row, in_row_next, out_row, out_row_next;
  logic [SB-1:0] in_slot, in_slot_next, out_slot, out_slot_next;
  logic          in_complete_next;

  // Output position seen by this beat (zero when a sample starts a new frame)
  logic          restart;
  logic [CW-1:0] ob_col;
  logic [RW-1:0] ob_row;
  logic [SB-1:0] ob_slot;

  // Effective sizes and gaps
  logic [GB-1:0] lg, rg, ug, dg, dy;
  logic [CW-1:0] wm1, rx, x0;
  logic [RW-1:0] hm1, ry, y0;
  logic [CW:0]   x_sum;
  logic [RW:0]   y_sum;
  logic [SB:0]   slot_wide;
  logic          ready, last;

  assign cfg_hit = cfg_valid && (cfg_index <= ldif_pkg::CFG_HEIGHT);

  assign restart = accept && !item.mode && in_complete;
  assign ob_col  = restart ? '0 : out_col;
  assign ob_row  = restart ? '0 : out_row;
  assign ob_slot = restart ? '0 : out_slot;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      left_gap  <= ldif_pkg::RST_GAP;
      right_gap <= ldif_pkg::RST_GAP;
      upper_gap <= ldif_pkg::RST_GAP;
      lower_gap <= ldif_pkg::RST_GAP;
      img_w     <= ldif_pkg::RST_WIDTH;
      img_h     <= ldif_pkg::RST_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        ldif_pkg::CFG_LEFT_GAP:  left_gap  <= cfg_data[2:0];
        ldif_pkg::CFG_RIGHT_GAP: right_gap <= cfg_data[2:0];
        ldif_pkg::CFG_UPPER_GAP: upper_gap <= cfg_data[2:0];
        ldif_pkg::CFG_LOWER_GAP: lower_gap <= cfg_data[2:0];
        ldif_pkg::CFG_WIDTH:     img_w     <= cfg_data;
        ldif_pkg::CFG_HEIGHT:    img_h     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp gaps and frame size
  always_comb begin
    lg = (32'(left_gap)  > MAX_GAP) ? GB'(MAX_GAP) : GB'(left_gap);
    rg = (32'(right_gap) > MAX_GAP) ? GB'(MAX_GAP) : GB'(right_gap);
    ug = (32'(upper_gap) > MAX_GAP) ? GB'(MAX_GAP) : GB'(upper_gap);
    dg = (32'(lower_gap) > MAX_GAP) ? GB'(MAX_GAP) : GB'(lower_gap);
    if (img_w == 11'd0) begin
      wm1 = '0;
    end else if (32'(img_w) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(img_w - 11'd1);
    end
    if (img_h == 11'd0) begin
      hm1 = '0;
    end else if (32'(img_h) > MAX_HEIGHT) begin
      hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(img_h - 11'd1);
    end
  end

  // Window of the next output position
  always_comb begin
    x_sum = (CW+1)'(ob_col) + (CW+1)'(rg);
    rx    = (x_sum > (CW+1)'(wm1)) ? wm1 : CW'(x_sum);
    y_sum = (RW+1)'(ob_row) + (RW+1)'(dg);
    ry    = (y_sum > (RW+1)'(hm1)) ? hm1 : RW'(y_sum);
    x0    = (ob_col >= CW'(lg)) ? ob_col - CW'(lg) : '0;
    y0    = (ob_row >= RW'(ug)) ? ob_row - RW'(ug) : '0;
    dy    = GB'(ob_row - y0);
    if (ob_slot >= SB'(dy)) begin
      slot_wide = (SB+1)'(ob_slot) - (SB+1)'(dy);
    end else begin
      slot_wide = (SB+1)'(ob_slot) + (SB+1)'(STORE_ROWS) - (SB+1)'(dy);
    end
    last = (ob_col == wm1) && (ob_row == hm1);
  end

  assign job_x0    = x0;
  assign job_x1    = rx;
  assign job_slot  = SB'(slot_wide);
  assign job_cols  = NWB'(rx - x0) + NWB'(1);
  assign job_rows  = NWB'(ry - y0) + NWB'(1);
  assign job_last  = last;
  assign ram_wdata = item.pixel;

  // Position update, store write and job issue
  always_comb begin
    in_col_next      = in_col;
    in_row_next      = in_row;
    in_slot_next     = in_slot;
    in_complete_next = in_complete;
    out_col_next     = out_col;
    out_row_next     = out_row;
    out_slot_next    = out_slot;
    ram_we           = 1'b0;
    ram_waddr        = {in_slot, in_col};
    job_push         = 1'b0;
    ready            = 1'b0;
    if (cfg_hit) begin
      in_col_next = '0; in_row_next = '0; in_slot_next = '0;
      out_col_next = '0; out_row_next = '0; out_slot_next = '0;
      in_complete_next = 1'b0;
    end else if (accept) begin
      if (!item.mode) begin
        // a new sample after a complete frame starts the next one
        if (in_complete) begin
          in_col_next = '0; in_row_next = '0; in_slot_next = '0;
          out_col_next = '0; out_row_next = '0; out_slot_next = '0;
          in_complete_next = 1'b0;
        end
        ram_we    = 1'b1;
        ram_waddr = {in_slot_next, in_col_next};
        if (in_col_next == wm1) begin
          in_col_next = '0;
          if (in_row_next == hm1) begin
            in_row_next      = '0;
            in_slot_next     = '0;
            in_complete_next = 1'b1;
          end else begin
            in_row_next  = in_row_next + RW'(1);
            in_slot_next = (in_slot_next == SB'(STORE_ROWS - 1)) ? '0
                         : in_slot_next + SB'(1);
          end
        end else begin
          in_col_next = in_col_next + CW'(1);
        end
      end
      ready = in_complete_next || (in_row_next > ry)
           || ((in_row_next == ry) && (in_col_next > rx));
      if (ready) begin
        job_push = 1'b1;
        if (last) begin
          in_col_next = '0; in_row_next = '0; in_slot_next = '0;
          out_col_next = '0; out_row_next = '0; out_slot_next = '0;
          in_complete_next = 1'b0;
        end else if (ob_col == wm1) begin
          out_col_next  = '0;
          out_row_next  = ob_row + RW'(1);
          out_slot_next = (ob_slot == SB'(STORE_ROWS - 1)) ? '0
                        : ob_slot + SB'(1);
        end else begin
          out_col_next = ob_col + CW'(1);
        end
      end
    end
  end

  // Position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col      <= '0;
      in_row      <= '0;
      in_slot     <= '0;
      in_complete <= 1'b0;
      out_col     <= '0;
      out_row     <= '0;
      out_slot    <= '0;
    end else begin
      in_col      <= in_col_next;
      in_row      <= in_row_next;
      in_slot     <= in_slot_next;
      in_complete <= in_complete_next;
      out_col     <= out_col_next;
      out_row     <= out_row_next;
      out_slot    <= out_slot_next;
    end
  end

endmodule

/* src/ldif_back.sv */
// Back end: walks the window in the line store, then variance, square root
// and scaled division (or saturation) one step a cycle. Depends on ldif_pkg.
module ldif_back #(
  parameter int MAX_WIDTH = ldif_pkg::DEF_MAX_WIDTH,
  parameter int MAX_GAP   = ldif_pkg::DEF_MAX_GAP,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int SB  = $clog2(2 * MAX_GAP + 2),
  localparam int NWB = $clog2(2 * MAX_GAP + 2)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_take,
  input  logic [CW-1:0]       job_x0,
  input  logic [CW-1:0]       job_x1,
  input  logic [SB-1:0]       job_slot,
  input  logic [NWB-1:0]      job_cols,
  input  logic [NWB-1:0]      job_rows,
  input  logic                job_last,
  output logic [SB+CW-1:0]    rd_addr,
  input  logic [7:0]          rd_data,
  output logic                res_push,
  output ldif_pkg::out_item_t res_item,
  output logic                busy
);

  localparam int STORE_ROWS = 2 * MAX_GAP + 2;
  localparam int CNTMAX = (2 * MAX_GAP + 1) * (2 * MAX_GAP + 1);
  localparam int CB  = $clog2(CNTMAX + 1);
  localparam int SW  = $clog2(CNTMAX * 255 + 1);
  localparam int QB  = $clog2(CNTMAX * 65025 + 1);
  localparam int NB  = CB + QB;
  localparam int MB  = NB + 16;
  localparam int RB  = (MB + 1) / 2;
  localparam int STB = $clog2(RB + 1);
  localparam int DB  = $clog2(ldif_pkg::FULL_SCALE * CNTMAX + 1);
  localparam int XB  = RB + DB + 8;

  ldif_pkg::back_state_t state, state_next;

  // Window walk
  logic [CW-1:0]  x0, x1, col;
  logic [SB-1:0]  slot;
  logic [NWB-1:0] rows_left;
  logic           last, rd_pend;

  // Arithmetic
  logic [SW-1:0]  s;
  logic [QB-1:0]  q;
  logic [CB-1:0]  cnt;
  logic [DB-1:0]  d100;
  logic [NB-1:0]  p1, p2, n;
  logic [MB-1:0]  rem, rt, bitv, trial_sq;
  logic [STB-1:0] step;
  logic [XB-1:0]  divrem, trial_div;
  logic [2:0]     idx;
  logic [7:0]     k;
  logic           sat;

  assign rd_addr   = {slot, col};
  assign busy      = (state != ldif_pkg::B_IDLE);
  assign trial_sq  = rt + bitv;
  assign trial_div = XB'(d100) << idx;
  assign sat       = XB'(RB'(rt)) >= (XB'(d100) << 8);
  assign res_item.deviation  = k;
  assign res_item.frame_last = last;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldif_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshakes
  always_comb begin
    state_next = state;
    job_take   = 1'b0;
    res_push   = 1'b0;
    case (state)
      ldif_pkg::B_IDLE: begin
        if (job_valid) begin
          job_take   = 1'b1;
          state_next = ldif_pkg::B_WALK;
        end
      end
      ldif_pkg::B_WALK: begin
        if ((col == x1) && (rows_left == NWB'(1))) begin
          state_next = ldif_pkg::B_DRAIN;
        end
      end
      ldif_pkg::B_DRAIN: state_next = ldif_pkg::B_MUL;
      ldif_pkg::B_MUL:   state_next = ldif_pkg::B_SUB;
      ldif_pkg::B_SUB:   state_next = ldif_pkg::B_SCALE;
      ldif_pkg::B_SCALE: state_next = ldif_pkg::B_ROOT;
      ldif_pkg::B_ROOT: begin
        if (step == STB'(1)) begin
          state_next = ldif_pkg::B_SAT;
        end
      end
      ldif_pkg::B_SAT: begin
        state_next = sat ? ldif_pkg::B_PUSH : ldif_pkg::B_DIV;
      end
      ldif_pkg::B_DIV: begin
        if (idx == 3'd0) begin
          state_next = ldif_pkg::B_PUSH;
        end
      end
      ldif_pkg::B_PUSH: begin
        res_push   = 1'b1;
        state_next = ldif_pkg::B_IDLE;
      end
      default: state_next = ldif_pkg::B_IDLE;
    endcase
  end

  // Read-pending flag: data arrives in the cycle after each walk read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == ldif_pkg::B_WALK);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      s <= s + SW'(rd_data);
      q <= q + QB'(rd_data * rd_data);
    end
    case (state)
      ldif_pkg::B_IDLE: begin
        x0        <= job_x0;
        x1        <= job_x1;
        col       <= job_x0;
        slot      <= job_slot;
        rows_left <= job_rows;
        last      <= job_last;
        cnt       <= CB'(job_cols * job_rows);
        s         <= '0;
        q         <= '0;
      end
      ldif_pkg::B_WALK: begin
        if (col == x1) begin
          col       <= x0;
          slot      <= (slot == SB'(STORE_ROWS - 1)) ? '0 : slot + SB'(1);
          rows_left <= rows_left - NWB'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
      ldif_pkg::B_MUL: begin
        p1   <= NB'(cnt) * NB'(q);
        p2   <= NB'(s * s);
        d100 <= DB'(cnt) * DB'(ldif_pkg::FULL_SCALE);
      end
      ldif_pkg::B_SUB: n <= p1 - p2;
      ldif_pkg::B_SCALE: begin
        rem  <= MB'(n) * MB'(ldif_pkg::SCALE_FACTOR);
        rt   <= '0;
        bitv <= MB'(1) << (2 * (RB - 1));
        step <= STB'(RB);
      end
      // one bit of the root per cycle
      ldif_pkg::B_ROOT: begin
        if (rem >= trial_sq) begin
          rem <= rem - trial_sq;
          rt  <= (rt >> 1) + bitv;
        end else begin
          rt <= rt >> 1;
        end
        bitv <= bitv >> 2;
        step <= step - STB'(1);
      end
      ldif_pkg::B_SAT: begin
        divrem <= XB'(RB'(rt));
        idx    <= 3'd7;
        k      <= sat ? ldif_pkg::OUT_TOP : 8'd0;
      end
      // restoring division, one quotient bit per cycle
      ldif_pkg::B_DIV: begin
        if (divrem >= trial_div) begin
          divrem <= divrem - trial_div;
          k[idx] <= 1'b1;
        end
        idx <= idx - 3'd1;
      end
      default: ;
    endcase
  end

endmodule

/* src/local_deviation_image_filter_core.sv */
// Top level of the local deviation image filter: front end, job queue,
// back end, line store and result queue. Depends on ldif_pkg, ldif_ram,
// ldif_front and ldif_back.
//
//   channel  handshake        payload                     direction
//   input    push / full      in_item  (mode, pixel)      in
//   result   empty / pop      out_item (deviation, last)  out
//   config   cfg_valid/ready  cfg_index, cfg_data         in
//
// An item is taken when push is high and full is low; the back end's time
// per result is set by the window walk over the single store read port
// and the bit-serial root.
// The input side holds at most one outstanding window job ahead of the back end.
// Synchronous reset clears positions and queues and resets the config registers;
// store contents are not cleared. full rises while two jobs are outstanding,
// while a job is outstanding at frame end, or when the result queue has no room.
module local_deviation_image_filter_core #(
  parameter int MAX_WIDTH  = ldif_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ldif_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_GAP    = ldif_pkg::DEF_MAX_GAP
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ldif_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output ldif_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [10:0]         cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int SB  = $clog2(2 * MAX_GAP + 2);
  localparam int NWB = $clog2(2 * MAX_GAP + 2);
  localparam int JW  = 2 * CW + SB + 2 * NWB + 1;
  localparam int JPB = $clog2(ldif_pkg::JQ_DEPTH);
  localparam int RPB = $clog2(ldif_pkg::RES_DEPTH);

  logic accept, in_complete;

  // Store ports
  logic             ram_we;
  logic [SB+CW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  // Jobs
  logic           job_push, job_take, back_busy;
  logic [CW-1:0]  f_x0, f_x1, b_x0, b_x1;
  logic [SB-1:0]  f_slot, b_slot;
  logic [NWB-1:0] f_cols, f_rows, b_cols, b_rows;
  logic           f_last, b_last;
  logic [JW-1:0]  jq_mem [ldif_pkg::JQ_DEPTH];
  logic [JPB-1:0] jq_wp, jq_rp;
  logic [JPB:0]   jq_cnt;
  logic [JPB+1:0] jobs_out;

  // Results
  logic                res_push;
  ldif_pkg::out_item_t res_item;
  ldif_pkg::out_item_t res_mem [ldif_pkg::RES_DEPTH];
  logic [RPB-1:0]      res_wp, res_rp;
  logic [RPB:0]        res_cnt;
  logic                res_pop;

  // Input stalls at two outstanding jobs (any at frame end) or when jobs would overrun the result queue
  assign jobs_out  = (JPB+2)'(jq_cnt) + (JPB+2)'(back_busy);
  assign full      = (jobs_out >= (JPB+2)'(2))
                  || ((jobs_out != '0) && in_complete)
                  || (32'(jobs_out) + 32'(res_cnt) >= ldif_pkg::RES_DEPTH);
  assign accept    = push && !full;
  assign cfg_ready = 1'b1;
  assign empty     = (res_cnt == '0);
  assign res_pop   = pop && !empty;
  assign out_item  = res_mem[res_rp];

  ldif_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_GAP   (MAX_GAP)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .item       (in_item),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .job_push   (job_push),
    .job_x0     (f_x0),
    .job_x1     (f_x1),
    .job_slot   (f_slot),
    .job_cols   (f_cols),
    .job_rows   (f_rows),
    .job_last   (f_last),
    .in_complete(in_complete)
  );

  ldif_ram #(
    .WIDTH(8),
    .DEPTH(1 << (SB + CW))
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Job queue between front and back; pointers wrap at the power-of-two depth
  always_ff @(posedge clk) begin
    if (job_push) begin
      jq_mem[jq_wp] <= {f_x0, f_x1, f_slot, f_cols, f_rows, f_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jq_wp  <= '0;
      jq_rp  <= '0;
      jq_cnt <= '0;
    end else begin
      if (job_push) jq_wp <= jq_wp + JPB'(1);
      if (job_take) jq_rp <= jq_rp + JPB'(1);
      jq_cnt <= jq_cnt + (JPB+1)'(job_push) - (JPB+1)'(job_take);
    end
  end

  assign {b_x0, b_x1, b_slot, b_cols, b_rows, b_last} = jq_mem[jq_rp];

  ldif_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_GAP  (MAX_GAP)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(jq_cnt != '0),
    .job_take (job_take),
    .job_x0   (b_x0),
    .job_x1   (b_x1),
    .job_slot (b_slot),
    .job_cols (b_cols),
    .job_rows (b_rows),
    .job_last (b_last),
    .rd_addr  (ram_raddr),
    .rd_data  (ram_rdata),
    .res_push (res_push),
    .res_item (res_item),
    .busy     (back_busy)
  );

  // Result queue
  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wp] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wp  <= '0;
      res_rp  <= '0;
      res_cnt <= '0;
    end else begin
      if (res_push) res_wp <= res_wp + RPB'(1);
      if (res_pop)  res_rp <= res_rp + RPB'(1);
      res_cnt <= res_cnt + (RPB+1)'(res_push) - (RPB+1)'(res_pop);
    end
  end

  // Checks
  a_jobs_bound: assert property (@(posedge clk) disable iff (rst)
    jobs_out <= (JPB+2)'(2))
    else $error("more than two window jobs outstanding");

  a_room: assert property (@(posedge clk) disable iff (rst)
    32'(jobs_out) + 32'(res_cnt) <= ldif_pkg::RES_DEPTH)
    else $error("outstanding jobs exceed result queue room");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (32'(res_cnt) < ldif_pkg::RES_DEPTH))
    else $error("result written into a full queue");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && in_complete) |-> (jobs_out == '0))
    else $error("new frame started with a job outstanding");

endmodule
